// ===== src/masked_bitvector_alu_64_core_defines.svh =====
// Assertion macros for the checker file of the masked bitvector ALU.
// Depends on nothing; include by bare file name.
`ifndef MASKED_BITVECTOR_ALU_64_CORE_DEFINES_SVH
`define MASKED_BITVECTOR_ALU_64_CORE_DEFINES_SVH

// Same-cycle implication, off while reset is asserted.
`define MBVA_ASSERT_IMP(lbl, clk_s, rstn_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!(rstn_s)) (ante) |-> (cons)) \
    else $error("mbva: implication check failed");

// Next-cycle implication, off while reset is asserted.
`define MBVA_ASSERT_NXT(lbl, clk_s, rstn_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!(rstn_s)) (ante) |=> (cons)) \
    else $error("mbva: next-cycle check failed");

// Next-cycle implication that also holds across reset.
`define MBVA_ASSERT_NXT_ALWAYS(lbl, clk_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) (ante) |=> (cons)) \
    else $error("mbva: reset check failed");

`endif

// ===== src/mbva_pkg.sv =====
// Package for the masked bitvector ALU: field widths, opcodes, stage control type.
// No dependencies.
`default_nettype none

package mbva_pkg;

  // Field widths of the channels
  localparam int OPCODE_W = 5;
  localparam int BW_W     = 7;
  localparam int AMT_W    = 7;
  localparam int XW       = 64;

  // Default datapath width
  localparam int DATA_WIDTH_DEF = 64;

  // Opcodes
  localparam logic [OPCODE_W-1:0] OP_ADD       = 5'd0;
  localparam logic [OPCODE_W-1:0] OP_SUB       = 5'd1;
  localparam logic [OPCODE_W-1:0] OP_MUL       = 5'd2;
  localparam logic [OPCODE_W-1:0] OP_AND       = 5'd3;
  localparam logic [OPCODE_W-1:0] OP_OR        = 5'd4;
  localparam logic [OPCODE_W-1:0] OP_XOR       = 5'd5;
  localparam logic [OPCODE_W-1:0] OP_NOT       = 5'd6;
  localparam logic [OPCODE_W-1:0] OP_LSL       = 5'd7;
  localparam logic [OPCODE_W-1:0] OP_LSR       = 5'd8;
  localparam logic [OPCODE_W-1:0] OP_ASR       = 5'd9;
  localparam logic [OPCODE_W-1:0] OP_EQ        = 5'd10;
  localparam logic [OPCODE_W-1:0] OP_NE        = 5'd11;
  localparam logic [OPCODE_W-1:0] OP_APPEND    = 5'd12;
  localparam logic [OPCODE_W-1:0] OP_REPLICATE = 5'd13;
  localparam logic [OPCODE_W-1:0] OP_SEXT      = 5'd14;
  localparam logic [OPCODE_W-1:0] OP_PASS      = 5'd15;
  localparam logic [OPCODE_W-1:0] OP_TOSIGNED  = 5'd16;
  localparam logic [OPCODE_W-1:0] OP_INTMASK   = 5'd17;
  localparam logic [OPCODE_W-1:0] OP_ONES      = 5'd18;
  localparam logic [OPCODE_W-1:0] OP_ZEROS     = 5'd19;

  // Control carried from the operate stage to the output stage
  typedef struct packed {
    logic [OPCODE_W-1:0] opcode;
    logic                compare_flag;
    logic                hi_fill;
  } ctl_t;

endpackage

`default_nettype wire

// ===== src/mbva_in_reg.sv =====
// Input register stage of the masked bitvector ALU: holds one beat of operands.
// Depends on mbva_pkg.
`default_nettype none

module mbva_in_reg (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          up_valid,
  output logic                               up_ready,
  input  wire logic [mbva_pkg::OPCODE_W-1:0] up_opcode,
  input  wire logic [mbva_pkg::BW_W-1:0]     up_bit_width,
  input  wire logic [mbva_pkg::XW-1:0]       up_x_operand,
  input  wire logic [mbva_pkg::XW-1:0]       up_y_operand,
  input  wire logic [mbva_pkg::AMT_W-1:0]    up_amount,
  output logic                               dn_valid,
  input  wire logic                          dn_ready,
  output logic [mbva_pkg::OPCODE_W-1:0]      dn_opcode,
  output logic [mbva_pkg::BW_W-1:0]          dn_bit_width,
  output logic [mbva_pkg::XW-1:0]            dn_x_operand,
  output logic [mbva_pkg::XW-1:0]            dn_y_operand,
  output logic [mbva_pkg::AMT_W-1:0]         dn_amount
);

  logic                          valid_r;
  logic                          valid_nxt;
  logic [mbva_pkg::OPCODE_W-1:0] opcode_r;
  logic [mbva_pkg::BW_W-1:0]     bit_width_r;
  logic [mbva_pkg::XW-1:0]       x_r;
  logic [mbva_pkg::XW-1:0]       y_r;
  logic [mbva_pkg::AMT_W-1:0]    amount_r;
  logic                          load;

  // Take a beat when empty or when the held beat moves on
  assign up_ready  = !valid_r || dn_ready;
  assign load      = up_valid && up_ready;
  assign valid_nxt = load ? 1'b1 : (dn_ready ? 1'b0 : valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Hold payload until the next beat lands
  always_ff @(posedge clk) begin
    if (load) begin
      opcode_r    <= up_opcode;
      bit_width_r <= up_bit_width;
      x_r         <= up_x_operand;
      y_r         <= up_y_operand;
      amount_r    <= up_amount;
    end
  end

  assign dn_valid     = valid_r;
  assign dn_opcode    = opcode_r;
  assign dn_bit_width = bit_width_r;
  assign dn_x_operand = x_r;
  assign dn_y_operand = y_r;
  assign dn_amount    = amount_r;

endmodule

`default_nettype wire

// ===== src/mbva_ops.sv =====
// Operate stage of the masked bitvector ALU: masking, logic, shifts, partial
// products and the first half of replicate, then a stage register. Uses mbva_pkg.
`default_nettype none

module mbva_ops #(
  parameter int DATA_WIDTH = mbva_pkg::DATA_WIDTH_DEF,
  localparam int WW = $clog2(DATA_WIDTH + 1),
  localparam int HI = DATA_WIDTH / 2,
  localparam int LO = DATA_WIDTH - HI
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          up_valid,
  output logic                               up_ready,
  input  wire logic [mbva_pkg::OPCODE_W-1:0] up_opcode,
  input  wire logic [mbva_pkg::BW_W-1:0]     up_bit_width,
  input  wire logic [mbva_pkg::XW-1:0]       up_x_operand,
  input  wire logic [mbva_pkg::XW-1:0]       up_y_operand,
  input  wire logic [mbva_pkg::AMT_W-1:0]    up_amount,
  output logic                               dn_valid,
  input  wire logic                          dn_ready,
  output mbva_pkg::ctl_t                     dn_ctl,
  output logic [DATA_WIDTH-1:0]              dn_part,
  output logic [2*LO-1:0]                    dn_pp_ll,
  output logic [HI-1:0]                      dn_pp_hl,
  output logic [HI-1:0]                      dn_pp_lh,
  output logic [DATA_WIDTH-1:0]              dn_mask,
  output logic [DATA_WIDTH-1:0]              dn_rep_pat,
  output logic [DATA_WIDTH-1:0]              dn_rep_mask,
  output logic [WW-1:0]                      dn_width
);

  localparam int RPW = WW + mbva_pkg::AMT_W;
  localparam logic [DATA_WIDTH-1:0] ONES = {DATA_WIDTH{1'b1}};

  logic                  valid_r;
  logic                  valid_nxt;
  logic                  load;
  logic [DATA_WIDTH-1:0] xd;
  logic [DATA_WIDTH-1:0] yd;
  logic [WW-1:0]         w_c;
  logic [WW-1:0]         n_c;
  logic [DATA_WIDTH-1:0] m_c;
  logic [DATA_WIDTH-1:0] xm;
  logic [DATA_WIDTH-1:0] ym;
  logic                  sbit;
  logic [DATA_WIDTH-1:0] part_c;
  logic                  flag_c;
  logic [LO-1:0]         xl;
  logic [LO-1:0]         yl;
  logic [HI-1:0]         xh;
  logic [HI-1:0]         yh;
  logic [2*LO-1:0]       pp_ll_c;
  logic [HI-1:0]         pp_hl_c;
  logic [HI-1:0]         pp_lh_c;
  logic [DATA_WIDTH-1:0] rp1;
  logic [DATA_WIDTH-1:0] rp2;
  logic [DATA_WIDTH-1:0] rp3;
  logic [RPW-1:0]        rep_len;
  logic [WW-1:0]         rep_n;
  mbva_pkg::ctl_t        ctl_c;

  mbva_pkg::ctl_t        ctl_r;
  logic [DATA_WIDTH-1:0] part_r;
  logic [2*LO-1:0]       pp_ll_r;
  logic [HI-1:0]         pp_hl_r;
  logic [HI-1:0]         pp_lh_r;
  logic [DATA_WIDTH-1:0] mask_r;
  logic [DATA_WIDTH-1:0] rep_pat_r;
  logic [DATA_WIDTH-1:0] rep_mask_r;
  logic [WW-1:0]         width_r;

  // Cut operands to the word, saturate the widths, build the width mask
  assign xd   = up_x_operand[DATA_WIDTH-1:0];
  assign yd   = up_y_operand[DATA_WIDTH-1:0];
  assign w_c  = (up_bit_width > mbva_pkg::BW_W'(DATA_WIDTH)) ? WW'(DATA_WIDTH)
                                                             : WW'(up_bit_width);
  assign n_c  = (up_amount > mbva_pkg::AMT_W'(DATA_WIDTH)) ? WW'(DATA_WIDTH)
                                                           : WW'(up_amount);
  assign m_c  = ~(ONES << w_c);
  assign xm   = xd & m_c;
  assign ym   = yd & m_c;
  // Top bit of the w-bit value: the one bit in the mask but not in mask >> 1
  assign sbit = |(xm & ~(m_c >> 1));

  // Partial products of the low word of x * y
  assign xl      = xd[LO-1:0];
  assign yl      = yd[LO-1:0];
  assign xh      = xd[DATA_WIDTH-1:LO];
  assign yh      = yd[DATA_WIDTH-1:LO];
  assign pp_ll_c = (2*LO)'(xl) * (2*LO)'(yl);
  assign pp_hl_c = HI'(xh * yl);
  assign pp_lh_c = HI'(xl * yh);

  // Replicate: double the pattern three times (w, 2w, 4w)
  assign rp1 = xm  | (xm  << w_c);
  assign rp2 = rp1 | (rp1 << {w_c, 1'b0});
  assign rp3 = rp2 | (rp2 << {w_c, 2'b0});

  // Replicate keeps amount * w bits, saturated to the word
  assign rep_len = RPW'(up_amount) * RPW'(w_c);
  assign rep_n   = (rep_len >= RPW'(DATA_WIDTH)) ? WW'(DATA_WIDTH) : WW'(rep_len);

  // Single-stage operations
  always_comb begin
    part_c = '0;
    flag_c = 1'b0;
    case (up_opcode)
      mbva_pkg::OP_ADD:      part_c = (xd + yd) & m_c;
      mbva_pkg::OP_SUB:      part_c = (xd - yd) & m_c;
      mbva_pkg::OP_AND:      part_c = xm & ym;
      mbva_pkg::OP_OR:       part_c = xm | ym;
      mbva_pkg::OP_XOR:      part_c = xm ^ ym;
      mbva_pkg::OP_NOT:      part_c = ~xd & m_c;
      mbva_pkg::OP_LSL:      part_c = (xm << up_amount) & m_c;
      mbva_pkg::OP_LSR:      part_c = xm >> up_amount;
      mbva_pkg::OP_ASR: begin
        if (sbit) begin
          part_c = ~((~xm & m_c) >> up_amount) & m_c;
        end else begin
          part_c = xm >> up_amount;
        end
      end
      mbva_pkg::OP_EQ:       flag_c = (xm == ym);
      mbva_pkg::OP_NE:       flag_c = (xm != ym);
      mbva_pkg::OP_APPEND:   part_c = (xd << up_amount) | yd;
      mbva_pkg::OP_SEXT:     part_c = xm | (sbit ? (~(ONES << n_c) & ~m_c) : '0);
      mbva_pkg::OP_PASS:     part_c = xd;
      mbva_pkg::OP_TOSIGNED: part_c = xm | (sbit ? ~m_c : '0);
      mbva_pkg::OP_INTMASK:  part_c = xd & m_c;
      mbva_pkg::OP_ONES:     part_c = m_c;
      default:               part_c = '0;
    endcase
  end

  always_comb begin
    ctl_c              = '0;
    ctl_c.opcode       = up_opcode;
    ctl_c.compare_flag = flag_c;
    ctl_c.hi_fill      = (up_opcode == mbva_pkg::OP_TOSIGNED) && sbit;
  end

  // Advance when the output stage can take the beat
  assign up_ready  = !valid_r || dn_ready;
  assign load      = up_valid && up_ready;
  assign valid_nxt = load ? 1'b1 : (dn_ready ? 1'b0 : valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      ctl_r      <= ctl_c;
      part_r     <= part_c;
      pp_ll_r    <= pp_ll_c;
      pp_hl_r    <= pp_hl_c;
      pp_lh_r    <= pp_lh_c;
      mask_r     <= m_c;
      rep_pat_r  <= rp3;
      rep_mask_r <= ~(ONES << rep_n);
      width_r    <= w_c;
    end
  end

  assign dn_valid    = valid_r;
  assign dn_ctl      = ctl_r;
  assign dn_part     = part_r;
  assign dn_pp_ll    = pp_ll_r;
  assign dn_pp_hl    = pp_hl_r;
  assign dn_pp_lh    = pp_lh_r;
  assign dn_mask     = mask_r;
  assign dn_rep_pat  = rep_pat_r;
  assign dn_rep_mask = rep_mask_r;
  assign dn_width    = width_r;

endmodule

`default_nettype wire

// ===== src/mbva_out_stage.sv =====
// Output stage of the masked bitvector ALU: sums the partial products, finishes
// replicate, selects the result and holds it in the output register. Uses mbva_pkg.
`default_nettype none

module mbva_out_stage #(
  parameter int DATA_WIDTH = mbva_pkg::DATA_WIDTH_DEF,
  localparam int WW = $clog2(DATA_WIDTH + 1),
  localparam int HI = DATA_WIDTH / 2,
  localparam int LO = DATA_WIDTH - HI
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    up_valid,
  output logic                         up_ready,
  input  wire mbva_pkg::ctl_t          up_ctl,
  input  wire logic [DATA_WIDTH-1:0]   up_part,
  input  wire logic [2*LO-1:0]         up_pp_ll,
  input  wire logic [HI-1:0]           up_pp_hl,
  input  wire logic [HI-1:0]           up_pp_lh,
  input  wire logic [DATA_WIDTH-1:0]   up_mask,
  input  wire logic [DATA_WIDTH-1:0]   up_rep_pat,
  input  wire logic [DATA_WIDTH-1:0]   up_rep_mask,
  input  wire logic [WW-1:0]           up_width,
  output logic                         out_valid,
  input  wire logic                    out_ready,
  output logic [mbva_pkg::XW-1:0]      out_result,
  output logic                         out_compare_flag
);

  // Bits of the 64-bit result above the word, set for a negative tosigned
  localparam logic [mbva_pkg::XW-1:0] UPPER = ~mbva_pkg::XW'({DATA_WIDTH{1'b1}});

  logic                      valid_r;
  logic                      valid_nxt;
  logic                      load;
  logic [DATA_WIDTH-1:0]     prod;
  logic [DATA_WIDTH-1:0]     rp4;
  logic [DATA_WIDTH-1:0]     rp5;
  logic [DATA_WIDTH-1:0]     rp6;
  logic [DATA_WIDTH-1:0]     sel;
  logic [mbva_pkg::XW-1:0]   result_nxt;
  logic [mbva_pkg::XW-1:0]   result_r;
  logic                      flag_r;

  // Low word of the product: low partial plus the shifted cross terms
  assign prod = DATA_WIDTH'(up_pp_ll)
              + ((DATA_WIDTH'(up_pp_hl) + DATA_WIDTH'(up_pp_lh)) << LO);

  // Replicate: three more doublings (8w, 16w, 32w)
  assign rp4 = up_rep_pat | (up_rep_pat << {up_width, 3'b000});
  assign rp5 = rp4 | (rp4 << {up_width, 4'b0000});
  assign rp6 = rp5 | (rp5 << {up_width, 5'b00000});

  always_comb begin
    case (up_ctl.opcode)
      mbva_pkg::OP_MUL:       sel = prod & up_mask;
      mbva_pkg::OP_REPLICATE: sel = rp6 & up_rep_mask;
      default:                sel = up_part;
    endcase
  end

  assign result_nxt = mbva_pkg::XW'(sel) | (up_ctl.hi_fill ? UPPER : '0);

  // Output register: drop the beat once the receiver takes it
  assign up_ready  = !valid_r || out_ready;
  assign load      = up_valid && up_ready;
  assign valid_nxt = load ? 1'b1 : (out_ready ? 1'b0 : valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result_r <= result_nxt;
      flag_r   <= up_ctl.compare_flag;
    end
  end

  assign out_valid        = valid_r;
  assign out_result       = result_r;
  assign out_compare_flag = flag_r;

endmodule

`default_nettype wire

// ===== src/masked_bitvector_alu_64_core.sv =====
// Masked bitvector ALU for run-time widths 0..DATA_WIDTH held in 64-bit words.
// Each input beat carries opcode, bit_width, x_operand, y_operand and amount;
// each accepted beat yields exactly one result beat (result, compare_flag),
// in order.
// Channels: in_* and out_* use valid/ready; a beat moves when both are high.
// Path: each beat passes the input register, then the operate register, then
// the output register.
// Throughput: one beat per cycle unless out_ready stalls; the 64x64 multiply is
// split into three 32x32 partial products across the operate and output stages.
// Stall: when out_ready is low the result holds in the output register, the
// stages behind it keep filling, and in_ready falls only once all three
// registers are full.
// Reset: rst_n (synchronous, active low) empties every stage; no settings or
// state survive between beats.
// Depends on mbva_pkg, mbva_in_reg, mbva_ops and mbva_out_stage.
`default_nettype none

module masked_bitvector_alu_64_core #(
  parameter int DATA_WIDTH = mbva_pkg::DATA_WIDTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [mbva_pkg::OPCODE_W-1:0] in_opcode,
  input  wire logic [mbva_pkg::BW_W-1:0]     in_bit_width,
  input  wire logic [mbva_pkg::XW-1:0]       in_x_operand,
  input  wire logic [mbva_pkg::XW-1:0]       in_y_operand,
  input  wire logic [mbva_pkg::AMT_W-1:0]    in_amount,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [mbva_pkg::XW-1:0]            out_result,
  output logic                               out_compare_flag
);

  localparam int WW = $clog2(DATA_WIDTH + 1);
  localparam int HI = DATA_WIDTH / 2;
  localparam int LO = DATA_WIDTH - HI;

  logic                          s1_valid;
  logic                          s1_ready;
  logic [mbva_pkg::OPCODE_W-1:0] s1_opcode;
  logic [mbva_pkg::BW_W-1:0]     s1_bit_width;
  logic [mbva_pkg::XW-1:0]       s1_x;
  logic [mbva_pkg::XW-1:0]       s1_y;
  logic [mbva_pkg::AMT_W-1:0]    s1_amount;

  logic                          s2_valid;
  logic                          s2_ready;
  mbva_pkg::ctl_t                s2_ctl;
  logic [DATA_WIDTH-1:0]         s2_part;
  logic [2*LO-1:0]               s2_pp_ll;
  logic [HI-1:0]                 s2_pp_hl;
  logic [HI-1:0]                 s2_pp_lh;
  logic [DATA_WIDTH-1:0]         s2_mask;
  logic [DATA_WIDTH-1:0]         s2_rep_pat;
  logic [DATA_WIDTH-1:0]         s2_rep_mask;
  logic [WW-1:0]                 s2_width;

  // Capture the input beat
  mbva_in_reg u_in_reg (
    .clk          (clk),
    .rst_n        (rst_n),
    .up_valid     (in_valid),
    .up_ready     (in_ready),
    .up_opcode    (in_opcode),
    .up_bit_width (in_bit_width),
    .up_x_operand (in_x_operand),
    .up_y_operand (in_y_operand),
    .up_amount    (in_amount),
    .dn_valid     (s1_valid),
    .dn_ready     (s1_ready),
    .dn_opcode    (s1_opcode),
    .dn_bit_width (s1_bit_width),
    .dn_x_operand (s1_x),
    .dn_y_operand (s1_y),
    .dn_amount    (s1_amount)
  );

  // Operate and form partial products
  mbva_ops #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_ops (
    .clk          (clk),
    .rst_n        (rst_n),
    .up_valid     (s1_valid),
    .up_ready     (s1_ready),
    .up_opcode    (s1_opcode),
    .up_bit_width (s1_bit_width),
    .up_x_operand (s1_x),
    .up_y_operand (s1_y),
    .up_amount    (s1_amount),
    .dn_valid     (s2_valid),
    .dn_ready     (s2_ready),
    .dn_ctl       (s2_ctl),
    .dn_part      (s2_part),
    .dn_pp_ll     (s2_pp_ll),
    .dn_pp_hl     (s2_pp_hl),
    .dn_pp_lh     (s2_pp_lh),
    .dn_mask      (s2_mask),
    .dn_rep_pat   (s2_rep_pat),
    .dn_rep_mask  (s2_rep_mask),
    .dn_width     (s2_width)
  );

  // Finish and register the result
  mbva_out_stage #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_out_stage (
    .clk              (clk),
    .rst_n            (rst_n),
    .up_valid         (s2_valid),
    .up_ready         (s2_ready),
    .up_ctl           (s2_ctl),
    .up_part          (s2_part),
    .up_pp_ll         (s2_pp_ll),
    .up_pp_hl         (s2_pp_hl),
    .up_pp_lh         (s2_pp_lh),
    .up_mask          (s2_mask),
    .up_rep_pat       (s2_rep_pat),
    .up_rep_mask      (s2_rep_mask),
    .up_width         (s2_width),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_result       (out_result),
    .out_compare_flag (out_compare_flag)
  );

endmodule

`default_nettype wire

// ===== src/mbva_chk.sv =====
// Port-level checker for the masked bitvector ALU, bound to the top level.
// Depends on mbva_pkg and masked_bitvector_alu_64_core_defines.svh.
`default_nettype none

`include "masked_bitvector_alu_64_core_defines.svh"

module mbva_chk (
  input wire logic                          clk,
  input wire logic                          rst_n,
  input wire logic                          in_ready,
  input wire logic                          out_valid,
  input wire logic                          out_ready,
  input wire logic [mbva_pkg::XW-1:0]       out_result,
  input wire logic                          out_compare_flag
);

  // Reset empties the output register
  `MBVA_ASSERT_NXT_ALWAYS(a_reset_empty, clk, !rst_n, !out_valid)

  // A stalled result beat stays put
  `MBVA_ASSERT_NXT(a_stall_hold, clk, rst_n, out_valid && !out_ready,
                   out_valid && $stable(out_result) && $stable(out_compare_flag))

  // Compare beats carry a zero result
  `MBVA_ASSERT_IMP(a_flag_zero, clk, rst_n, out_valid && out_compare_flag,
                   out_result == '0)

  // With the output register empty, the pipeline has room for a beat
  `MBVA_ASSERT_IMP(a_room_when_empty, clk, rst_n, !out_valid, in_ready)

endmodule

bind masked_bitvector_alu_64_core mbva_chk u_mbva_chk (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_ready         (in_ready),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_result       (out_result),
  .out_compare_flag (out_compare_flag)
);

`default_nettype wire
